// File: rtl/core/lj_site_pair_force_defines.svh
// Assertion macros shared by the pair force RTL.
`ifndef LJ_SITE_PAIR_FORCE_DEFINES_SVH
`define LJ_SITE_PAIR_FORCE_DEFINES_SVH

`ifndef SYNTHESIS
`define LJSPF_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ljspf assertion failed");
`define LJSPF_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ljspf assertion failed");
`else
`define LJSPF_ASSERT_IMP(name, clk, rstn, ante, cons)
`define LJSPF_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/ljspf_pkg.sv
// Types, constants and helper functions of the pair force block.
`default_nettype none
package ljspf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int FORCE_W   = 48;
    localparam int COEF_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int EXP_W     = 12;

    localparam int E_SQ  = -2 * FRAC_BITS;
    localparam int E_C12 = 1 - FRAC_BITS;
    localparam int E_C6  = -FRAC_BITS;
    localparam int E_AD  = -FRAC_BITS;

    localparam int DIV_STG = 8;
    localparam int DIV_BPS = 32 / DIV_STG;
    localparam int DIV_S0  = 9;
    localparam int NSTG    = 25;

    localparam logic [FORCE_W-1:0] F_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] F_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    localparam logic [COEF_W-1:0] RST_CC_REP = 48'd7352483840000;
    localparam logic [COEF_W-1:0] RST_CC_ATT = 48'd3999688294;
    localparam logic [COEF_W-1:0] RST_HH_REP = 48'd58984366080;
    localparam logic [COEF_W-1:0] RST_HH_ATT = 48'd241599775;
    localparam logic [COEF_W-1:0] RST_CH_REP = 48'd822758604800;
    localparam logic [COEF_W-1:0] RST_CH_ATT = 48'd983020339;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CC_REP = 3'd0,
        CFG_CC_ATT = 3'd1,
        CFG_HH_REP = 3'd2,
        CFG_HH_ATT = 3'd3,
        CFG_CH_REP = 3'd4,
        CFG_CH_ATT = 3'd5
    } t_cfg_idx;

    typedef logic signed [EXP_W-1:0] t_exp;

    typedef struct packed {
        logic [31:0] m;
        t_exp        e;
    } t_pf;

    function automatic logic [6:0] msb66(input logic [65:0] v);
        logic [6:0] p;
        p = '0;
        for (int i = 0; i < 66; i++) begin
            if (v[i]) begin
                p = 7'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [31:0] nshift(input logic [65:0] v, input logic [6:0] p);
        logic [96:0] t;
        t = {v, 31'b0} >> p;
        return t[31:0];
    endfunction

    function automatic t_exp pos_exp(input t_exp base, input logic [6:0] p);
        return base + t_exp'({5'b0, p}) - t_exp'(31);
    endfunction

    function automatic t_pf pf_mnorm(input logic [63:0] p, input t_exp e);
        t_pf r;
        if (p[63]) begin
            r.m = p[63:32];
            r.e = e + t_exp'(32);
        end else begin
            r.m = p[62:31];
            r.e = e + t_exp'(31);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/ljspf_in_if.sv
// Input channel: one site pair per word.
`default_nettype none
interface ljspf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ljspf_pkg::COORD_W-1:0] first_x;
    logic signed [ljspf_pkg::COORD_W-1:0] first_y;
    logic signed [ljspf_pkg::COORD_W-1:0] first_z;
    logic signed [ljspf_pkg::COORD_W-1:0] second_x;
    logic signed [ljspf_pkg::COORD_W-1:0] second_y;
    logic signed [ljspf_pkg::COORD_W-1:0] second_z;
    logic                                first_is_carbon;
    logic                                second_is_carbon;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               first_is_carbon, second_is_carbon,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               first_is_carbon, second_is_carbon,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/core/ljspf_out_if.sv
// Output channel: one force result per word.
`default_nettype none
interface ljspf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ljspf_pkg::FORCE_W-1:0] force_x;
    logic signed [ljspf_pkg::FORCE_W-1:0] force_y;
    logic signed [ljspf_pkg::FORCE_W-1:0] force_z;
    logic                                saturated;
    logic                                coincident;

    modport source (
        output valid, force_x, force_y, force_z, saturated, coincident,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, force_z, saturated, coincident,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/core/ljspf_div.sv
// Pipelined restoring divider giving a 32-bit quotient, four bits per stage.
`default_nettype none
module ljspf_div (
    input  wire logic                            i_clk,
    input  wire logic [ljspf_pkg::DIV_STG-1:0]   i_en,
    input  wire logic [31:0]                     i_num,
    input  wire logic [31:0]                     i_den,
    output logic      [31:0]                     o_quo
);

    logic [31:0] r_rem [ljspf_pkg::DIV_STG];
    logic [31:0] r_quo [ljspf_pkg::DIV_STG];
    logic [31:0] r_den [ljspf_pkg::DIV_STG];
    logic [31:0] n_rem [ljspf_pkg::DIV_STG];
    logic [31:0] n_quo [ljspf_pkg::DIV_STG];
    logic [31:0] n_den [ljspf_pkg::DIV_STG];

    always_comb begin
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
        logic [32:0] t;
        logic        bin;
        for (int j = 0; j < ljspf_pkg::DIV_STG; j++) begin
            if (j == 0) begin
                rem = {1'b0, i_num[31:1]};
                quo = '0;
                den = i_den;
            end else begin
                rem = r_rem[j-1];
                quo = r_quo[j-1];
                den = r_den[j-1];
            end
            for (int b = 0; b < ljspf_pkg::DIV_BPS; b++) begin
                bin = (j == 0 && b == 0) ? i_num[0] : 1'b0;
                t = {rem, bin};
                if (t >= {1'b0, den}) begin
                    t   = t - {1'b0, den};
                    quo = {quo[30:0], 1'b1};
                end else begin
                    quo = {quo[30:0], 1'b0};
                end
                rem = t[31:0];
            end
            n_rem[j] = rem;
            n_quo[j] = quo;
            n_den[j] = den;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ljspf_pkg::DIV_STG; j++) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem[j];
                r_quo[j] <= n_quo[j];
                r_den[j] <= n_den[j];
            end
        end
    end

    assign o_quo = r_quo[ljspf_pkg::DIV_STG-1];

endmodule
`default_nettype wire

// File: rtl/core/lj_site_pair_force.sv
// Top level of the Lennard-Jones site pair force pipeline.
//
//   channel  dir  handshake      contents
//   i_in     in   valid/ready    two site positions and types
//   o_out    out  valid/ready    force on first site, saturated, coincident
//   cfg      in   i_cfg_we       six pair coefficients by index
//
// The pipeline has 25 register stages; one word can enter in every cycle
// unless a stalled output has filled every stage.
// The two divisions run in two eight-stage dividers, four quotient bits per stage.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stalled output and nothing is lost or repeated.
// Reset clears the valid bits and loads the default coefficients.
`default_nettype none
`include "lj_site_pair_force_defines.svh"
module lj_site_pair_force (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    ljspf_in_if.sink                                 i_in,
    ljspf_out_if.source                              o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [ljspf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ljspf_pkg::COEF_W-1:0]        i_cfg_data
);

    localparam int LAST = ljspf_pkg::NSTG - 1;

    typedef struct packed {
        logic [2:0]         dneg;
        logic [2:0][32:0]   ad;
        logic [2:0][6:0]    adp;
        logic [2:0][31:0]   adm;
        logic [2:0][11:0]   ade;
        logic [2:0]         adz;
        logic [47:0]        c12;
        logic [47:0]        c6;
        logic [6:0]         c12p;
        logic [6:0]         c6p;
        ljspf_pkg::t_pf     ca;
        ljspf_pkg::t_pf     cb;
        logic               az;
        logic               bz;
        logic [2:0][65:0]   sq;
        logic [65:0]        sum;
        logic [6:0]         sp;
        logic               coin;
        ljspf_pkg::t_pf     s;
        logic [63:0]        p2;
        ljspf_pkg::t_exp    p2e;
        logic [63:0]        p3;
        logic [63:0]        p4;
        ljspf_pkg::t_exp    p3e;
        ljspf_pkg::t_exp    p4e;
        ljspf_pkg::t_pf     s4;
        logic [63:0]        p7;
        ljspf_pkg::t_exp    p7e;
        ljspf_pkg::t_pf     s7;
        ljspf_pkg::t_exp    ea;
        ljspf_pkg::t_exp    eb;
        ljspf_pkg::t_pf     bg;
        logic [31:0]        lo_m;
        ljspf_pkg::t_exp    diff;
        logic               dn;
        logic [62:0]        x;
        ljspf_pkg::t_exp    xe;
        logic [6:0]         xp;
        ljspf_pkg::t_pf     dd;
        logic               dz;
        ljspf_pkg::t_pf     k;
        logic [2:0][63:0]   pr;
        logic [2:0][11:0]   pre;
        logic [2:0]         prz;
        logic [2:0][47:0]   mag;
        logic [2:0]         ovf;
        logic [2:0][47:0]   frc;
        logic               sat;
    } t_pl;

    logic [ljspf_pkg::COEF_W-1:0] r_cc_rep, r_cc_att, r_hh_rep;
    logic [ljspf_pkg::COEF_W-1:0] r_hh_att, r_ch_rep, r_ch_att;

    logic [LAST:0] r_vld;
    logic [LAST:0] stg_en;
    t_pl           r_p [ljspf_pkg::NSTG];
    t_pl           n_p [ljspf_pkg::NSTG];
    logic [31:0]   quo_a;
    logic [31:0]   quo_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_rep <= ljspf_pkg::RST_CC_REP;
            r_cc_att <= ljspf_pkg::RST_CC_ATT;
            r_hh_rep <= ljspf_pkg::RST_HH_REP;
            r_hh_att <= ljspf_pkg::RST_HH_ATT;
            r_ch_rep <= ljspf_pkg::RST_CH_REP;
            r_ch_att <= ljspf_pkg::RST_CH_ATT;
        end else if (i_cfg_we) begin
            unique case (ljspf_pkg::t_cfg_idx'(i_cfg_idx))
                ljspf_pkg::CFG_CC_REP: r_cc_rep <= i_cfg_data;
                ljspf_pkg::CFG_CC_ATT: r_cc_att <= i_cfg_data;
                ljspf_pkg::CFG_HH_REP: r_hh_rep <= i_cfg_data;
                ljspf_pkg::CFG_HH_ATT: r_hh_att <= i_cfg_data;
                ljspf_pkg::CFG_CH_REP: r_ch_rep <= i_cfg_data;
                ljspf_pkg::CFG_CH_ATT: r_ch_att <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        stg_en[LAST] = !r_vld[LAST] || o_out.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign i_in.ready = stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= LAST; k++) begin
            if (stg_en[k]) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    ljspf_div u_div_a (
        .i_clk (i_clk),
        .i_en  (stg_en[ljspf_pkg::DIV_S0 +: ljspf_pkg::DIV_STG]),
        .i_num (r_p[ljspf_pkg::DIV_S0-1].ca.m),
        .i_den (r_p[ljspf_pkg::DIV_S0-1].s7.m),
        .o_quo (quo_a)
    );

    ljspf_div u_div_b (
        .i_clk (i_clk),
        .i_en  (stg_en[ljspf_pkg::DIV_S0 +: ljspf_pkg::DIV_STG]),
        .i_num (r_p[ljspf_pkg::DIV_S0-1].cb.m),
        .i_den (r_p[ljspf_pkg::DIV_S0-1].s4.m),
        .o_quo (quo_b)
    );

    always_comb begin
        logic [32:0]     d;
        logic            c1;
        logic            c2;
        ljspf_pkg::t_pf  s2;
        ljspf_pkg::t_pf  s3;
        ljspf_pkg::t_pf  fa;
        ljspf_pkg::t_pf  fb;
        ljspf_pkg::t_pf  pf;
        logic            abig;
        logic [4:0]      sh;
        ljspf_pkg::t_exp rs;
        logic [31:0]     lsh;
        logic [33:0]     t3;
        ljspf_pkg::t_exp kk;
        ljspf_pkg::t_exp nk;
        logic            neg;

        n_p[0] = r_p[0];
        for (int k = 1; k <= LAST; k++) begin
            n_p[k] = r_p[k-1];
        end

        // Displacement, magnitude and coefficient selection.
        d = {i_in.first_x[31], i_in.first_x} - {i_in.second_x[31], i_in.second_x};
        n_p[0].dneg[0] = d[32];
        n_p[0].ad[0]   = d[32] ? -d : d;
        d = {i_in.first_y[31], i_in.first_y} - {i_in.second_y[31], i_in.second_y};
        n_p[0].dneg[1] = d[32];
        n_p[0].ad[1]   = d[32] ? -d : d;
        d = {i_in.first_z[31], i_in.first_z} - {i_in.second_z[31], i_in.second_z};
        n_p[0].dneg[2] = d[32];
        n_p[0].ad[2]   = d[32] ? -d : d;
        c1 = i_in.first_is_carbon;
        c2 = i_in.second_is_carbon;
        if (c1 && c2) begin
            n_p[0].c12 = r_cc_rep;
            n_p[0].c6  = r_cc_att;
        end else if (!c1 && !c2) begin
            n_p[0].c12 = r_hh_rep;
            n_p[0].c6  = r_hh_att;
        end else begin
            n_p[0].c12 = r_ch_rep;
            n_p[0].c6  = r_ch_att;
        end

        for (int i = 0; i < 3; i++) begin
            n_p[1].sq[i]  = r_p[0].ad[i] * r_p[0].ad[i];
            n_p[1].adp[i] = ljspf_pkg::msb66({33'b0, r_p[0].ad[i]});
        end
        n_p[1].c12p = ljspf_pkg::msb66({18'b0, r_p[0].c12});
        n_p[1].c6p  = ljspf_pkg::msb66({18'b0, r_p[0].c6});

        n_p[2].sum = r_p[1].sq[0] + r_p[1].sq[1] + r_p[1].sq[2];
        for (int i = 0; i < 3; i++) begin
            n_p[2].adm[i] = ljspf_pkg::nshift({33'b0, r_p[1].ad[i]}, r_p[1].adp[i]);
            n_p[2].ade[i] = ljspf_pkg::pos_exp(ljspf_pkg::t_exp'(ljspf_pkg::E_AD),
                                               r_p[1].adp[i]);
            n_p[2].adz[i] = (r_p[1].ad[i] == '0);
        end
        n_p[2].ca.m = ljspf_pkg::nshift({18'b0, r_p[1].c12}, r_p[1].c12p);
        n_p[2].ca.e = ljspf_pkg::pos_exp(ljspf_pkg::t_exp'(ljspf_pkg::E_C12), r_p[1].c12p);
        n_p[2].az   = (r_p[1].c12 == '0);
        n_p[2].cb.m = ljspf_pkg::nshift({18'b0, r_p[1].c6}, r_p[1].c6p);
        n_p[2].cb.e = ljspf_pkg::pos_exp(ljspf_pkg::t_exp'(ljspf_pkg::E_C6), r_p[1].c6p);
        n_p[2].bz   = (r_p[1].c6 == '0);

        n_p[3].sp   = ljspf_pkg::msb66(r_p[2].sum);
        n_p[3].coin = (r_p[2].sum == '0);

        n_p[4].s.m = ljspf_pkg::nshift(r_p[3].sum, r_p[3].sp);
        n_p[4].s.e = ljspf_pkg::pos_exp(ljspf_pkg::t_exp'(ljspf_pkg::E_SQ), r_p[3].sp);

        n_p[5].p2  = r_p[4].s.m * r_p[4].s.m;
        n_p[5].p2e = r_p[4].s.e + r_p[4].s.e;

        s2 = ljspf_pkg::pf_mnorm(r_p[5].p2, r_p[5].p2e);
        n_p[6].p3  = s2.m * r_p[5].s.m;
        n_p[6].p3e = s2.e + r_p[5].s.e;
        n_p[6].p4  = s2.m * s2.m;
        n_p[6].p4e = s2.e + s2.e;

        s3 = ljspf_pkg::pf_mnorm(r_p[6].p3, r_p[6].p3e);
        n_p[7].s4  = ljspf_pkg::pf_mnorm(r_p[6].p4, r_p[6].p4e);
        n_p[7].p7  = n_p[7].s4.m * s3.m;
        n_p[7].p7e = n_p[7].s4.e + s3.e;

        n_p[8].s7 = ljspf_pkg::pf_mnorm(r_p[7].p7, r_p[7].p7e);

        n_p[9].ea = r_p[8].ca.e - r_p[8].s7.e - ljspf_pkg::t_exp'(31);
        n_p[9].eb = r_p[8].cb.e - r_p[8].s4.e - ljspf_pkg::t_exp'(31);

        // Quotient normalization, then order the operands of the difference.
        fa.m = quo_a[31] ? quo_a : {quo_a[30:0], 1'b0};
        fa.e = quo_a[31] ? r_p[16].ea : r_p[16].ea - ljspf_pkg::t_exp'(1);
        fb.m = quo_b[31] ? quo_b : {quo_b[30:0], 1'b0};
        fb.e = quo_b[31] ? r_p[16].eb : r_p[16].eb - ljspf_pkg::t_exp'(1);
        abig = r_p[16].bz || (!r_p[16].az && ((fa.e > fb.e) ||
               (fa.e == fb.e && fa.m >= fb.m)));
        n_p[17].dn = !abig;
        if (abig) begin
            n_p[17].bg = r_p[16].az ? '0 : fa;
            if (r_p[16].bz) begin
                n_p[17].lo_m = '0;
                n_p[17].diff = '0;
            end else begin
                n_p[17].lo_m = fb.m;
                n_p[17].diff = fa.e - fb.e;
            end
        end else begin
            n_p[17].bg = fb;
            if (r_p[16].az) begin
                n_p[17].lo_m = '0;
                n_p[17].diff = '0;
            end else begin
                n_p[17].lo_m = fa.m;
                n_p[17].diff = fb.e - fa.e;
            end
        end

        sh  = (r_p[17].diff > ljspf_pkg::t_exp'(31)) ? 5'd31 : r_p[17].diff[4:0];
        rs  = r_p[17].diff - ljspf_pkg::t_exp'({7'b0, sh});
        lsh = (rs > ljspf_pkg::t_exp'(31)) ? '0 : (r_p[17].lo_m >> rs[4:0]);
        n_p[18].x  = ({31'b0, r_p[17].bg.m} << sh) - {31'b0, lsh};
        n_p[18].xe = r_p[17].bg.e - ljspf_pkg::t_exp'({7'b0, sh});

        n_p[19].xp = ljspf_pkg::msb66({3'b0, r_p[18].x});

        n_p[20].dd.m = ljspf_pkg::nshift({3'b0, r_p[19].x}, r_p[19].xp);
        n_p[20].dd.e = ljspf_pkg::pos_exp(r_p[19].xe, r_p[19].xp);
        n_p[20].dz   = (r_p[19].x == '0);

        // Scale by 24: mantissa times three, exponent raised by three (times eight).
        t3 = {2'b0, r_p[20].dd.m} + {1'b0, r_p[20].dd.m, 1'b0};
        n_p[21].k.m = t3[33] ? t3[33:2] : t3[32:1];
        n_p[21].k.e = r_p[20].dd.e + (t3[33] ? ljspf_pkg::t_exp'(5) : ljspf_pkg::t_exp'(4));

        for (int i = 0; i < 3; i++) begin
            n_p[22].pr[i]  = r_p[21].k.m * r_p[21].adm[i];
            n_p[22].pre[i] = r_p[21].k.e + $signed(r_p[21].ade[i]);
            n_p[22].prz[i] = r_p[21].dz || r_p[21].adz[i];
        end

        for (int i = 0; i < 3; i++) begin
            pf = ljspf_pkg::pf_mnorm(r_p[22].pr[i], $signed(r_p[22].pre[i]));
            kk = pf.e + ljspf_pkg::t_exp'(ljspf_pkg::FRAC_BITS);
            nk = -kk;
            n_p[23].mag[i] = '0;
            n_p[23].ovf[i] = 1'b0;
            priority if (r_p[22].prz[i]) begin
                n_p[23].mag[i] = '0;
            end else if (kk >= ljspf_pkg::t_exp'(16)) begin
                n_p[23].ovf[i] = 1'b1;
            end else if (kk >= ljspf_pkg::t_exp'(0)) begin
                n_p[23].mag[i] = {16'b0, pf.m} << kk[3:0];
            end else if (nk >= ljspf_pkg::t_exp'(32)) begin
                n_p[23].mag[i] = '0;
            end else begin
                n_p[23].mag[i] = {16'b0, pf.m >> nk[4:0]};
            end
        end

        n_p[24].sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            neg = r_p[23].dn ^ r_p[23].dneg[i];
            if (r_p[23].coin) begin
                n_p[24].frc[i] = '0;
            end else if (r_p[23].ovf[i]) begin
                n_p[24].frc[i] = neg ? ljspf_pkg::F_MIN : ljspf_pkg::F_MAX;
                n_p[24].sat    = 1'b1;
            end else begin
                n_p[24].frc[i] = neg ? -r_p[23].mag[i] : r_p[23].mag[i];
            end
        end
    end

    assign o_out.valid      = r_vld[LAST];
    assign o_out.force_x    = r_p[LAST].frc[0];
    assign o_out.force_y    = r_p[LAST].frc[1];
    assign o_out.force_z    = r_p[LAST].frc[2];
    assign o_out.saturated  = r_p[LAST].sat;
    assign o_out.coincident = r_p[LAST].coin;

    `LJSPF_ASSERT_IMP(a_coin_zero, i_clk, i_rst_n, o_out.valid && o_out.coincident, o_out.force_x == '0 && o_out.force_y == '0 && o_out.force_z == '0 && !o_out.saturated)
    `LJSPF_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, o_out.valid && o_out.saturated, o_out.force_x == ljspf_pkg::F_MAX || o_out.force_x == ljspf_pkg::F_MIN || o_out.force_y == ljspf_pkg::F_MAX || o_out.force_y == ljspf_pkg::F_MIN || o_out.force_z == ljspf_pkg::F_MAX || o_out.force_z == ljspf_pkg::F_MIN)
    `LJSPF_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_in.valid && i_in.ready, r_vld[0])
    `LJSPF_ASSERT_IMP(a_full_blocks, i_clk, i_rst_n, (&r_vld) && !o_out.ready, !i_in.ready)

endmodule
`default_nettype wire
